[sv/rwop_pkg.sv]
// Package for the random walk occupancy pulser.
// Register map, reset values, config and job types; no dependencies.
package rwop_pkg;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_GRID_EDGE  = 3'd0;
   localparam logic [2:0] REG_STEP_SIZE  = 3'd1;
   localparam logic [2:0] REG_BOX_X_LOW  = 3'd2;
   localparam logic [2:0] REG_BOX_X_HIGH = 3'd3;
   localparam logic [2:0] REG_BOX_Y_LOW  = 3'd4;
   localparam logic [2:0] REG_BOX_Y_HIGH = 3'd5;

   localparam int unsigned ADDR_BITS = 5;

   localparam logic [7:0] GRID_EDGE_RST = 8'd10;
   localparam logic [7:0] STEP_SIZE_RST = 8'd3;
   localparam logic [7:0] BOX_LOW_RST   = 8'd3;
   localparam logic [7:0] BOX_HIGH_RST  = 8'd8;

   // operation codes
   localparam logic OP_MOVE  = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   localparam logic [4:0] MAX_BURST = 5'd16;
   localparam logic [4:0] OCC_MAX   = 5'd31;

   typedef struct packed {
      logic [7:0] grid_edge;
      logic [7:0] step_size;
      logic [7:0] box_x_low;
      logic [7:0] box_x_high;
      logic [7:0] box_y_low;
      logic [7:0] box_y_high;
   } cfg_type;

   // one burst request from the update stage to the pulse generator
   typedef struct packed {
      logic       pulse;
      logic [4:0] occupancy;
      logic       multiple_present;
      logic [4:0] beats;
   } job_type;

endpackage

[sv/rwop_csr.sv]
// Configuration registers of the random walk occupancy pulser, APB-style access.
// Depends on rwop_pkg.
module rwop_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rwop_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output rwop_pkg::cfg_type               cfg
);

   rwop_pkg::cfg_type cfg_ff;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_edge  <= rwop_pkg::GRID_EDGE_RST;
         cfg_ff.step_size  <= rwop_pkg::STEP_SIZE_RST;
         cfg_ff.box_x_low  <= rwop_pkg::BOX_LOW_RST;
         cfg_ff.box_x_high <= rwop_pkg::BOX_HIGH_RST;
         cfg_ff.box_y_low  <= rwop_pkg::BOX_LOW_RST;
         cfg_ff.box_y_high <= rwop_pkg::BOX_HIGH_RST;
      end else if (wr_en) begin
         case (reg_idx)
            rwop_pkg::REG_GRID_EDGE:  cfg_ff.grid_edge  <= csr_pwdata[7:0];
            rwop_pkg::REG_STEP_SIZE:  cfg_ff.step_size  <= csr_pwdata[7:0];
            rwop_pkg::REG_BOX_X_LOW:  cfg_ff.box_x_low  <= csr_pwdata[7:0];
            rwop_pkg::REG_BOX_X_HIGH: cfg_ff.box_x_high <= csr_pwdata[7:0];
            rwop_pkg::REG_BOX_Y_LOW:  cfg_ff.box_y_low  <= csr_pwdata[7:0];
            rwop_pkg::REG_BOX_Y_HIGH: cfg_ff.box_y_high <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      case (reg_idx)
         rwop_pkg::REG_GRID_EDGE:  csr_prdata = {24'd0, cfg_ff.grid_edge};
         rwop_pkg::REG_STEP_SIZE:  csr_prdata = {24'd0, cfg_ff.step_size};
         rwop_pkg::REG_BOX_X_LOW:  csr_prdata = {24'd0, cfg_ff.box_x_low};
         rwop_pkg::REG_BOX_X_HIGH: csr_prdata = {24'd0, cfg_ff.box_x_high};
         rwop_pkg::REG_BOX_Y_LOW:  csr_prdata = {24'd0, cfg_ff.box_y_low};
         rwop_pkg::REG_BOX_Y_HIGH: csr_prdata = {24'd0, cfg_ff.box_y_high};
         default:                  csr_prdata = 32'd0;
      endcase
   end

endmodule

[sv/rwop_walker_store.sv]
// Walker state memory with read-modify-write update stage and occupancy count.
// Depends on rwop_pkg.
module rwop_walker_store #(
   parameter int WALKERS  = 16,
   parameter int POS_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  rwop_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [3:0]        req_walker_id,
   input  logic              req_x_negative,
   input  logic              req_y_negative,
   input  logic [7:0]        req_place_x,
   input  logic [7:0]        req_place_y,
   output logic              job_valid,
   output rwop_pkg::job_type job,
   input  logic              job_ready
);

   localparam int IW = (WALKERS > 1) ? $clog2(WALKERS) : 1;
   localparam int EW = (POS_BITS > 8) ? POS_BITS : 8;
   localparam int CW = $clog2(WALKERS + 1);
   localparam int MW = 2 * POS_BITS + 1;
   localparam logic [EW-1:0] PMAX = EW'((32'd1 << POS_BITS) - 32'd1);

   // entry layout: {in_box, y, x}
   logic [MW-1:0]  mem_ff [WALKERS];
   logic [WALKERS-1:0] vld_ff;

   logic           accept;
   logic           in_range;
   logic [IW-1:0]  req_idx;

   // update stage
   logic           s1_vld_ff;
   logic           s1_op_ff;
   logic           s1_in_range_ff;
   logic [IW-1:0]  s1_idx_ff;
   logic           s1_xneg_ff;
   logic           s1_yneg_ff;
   logic [7:0]     s1_px_ff;
   logic [7:0]     s1_py_ff;
   logic [MW-1:0]  rdata_ff;
   logic           rvld_ff;

   // bypass of the write that lands on the same edge as the read
   logic           fwd_vld_ff;
   logic [IW-1:0]  fwd_idx_ff;
   logic [MW-1:0]  fwd_data_ff;

   logic [CW-1:0]  count_ff;

   logic           s1_adv;
   logic           wr_en;
   logic [MW-1:0]  entry;
   logic [MW-1:0]  wr_data;
   logic [EW-1:0]  edge_eff;
   logic [EW-1:0]  step_eff;
   logic [EW-1:0]  old_x;
   logic [EW-1:0]  old_y;
   logic [EW-1:0]  new_x;
   logic [EW-1:0]  new_y;
   logic           old_flag;
   logic           new_flag;
   logic [CW-1:0]  count_in;

   function automatic logic [EW-1:0] wrap_step(input logic [EW-1:0] p,
                                               input logic [EW-1:0] step,
                                               input logic          down,
                                               input logic [EW-1:0] edge_v);
      logic [EW:0] sum;
      begin
         sum = {1'b0, p} + {1'b0, step};
         if (down) begin
            if (p < step) wrap_step = EW'({1'b0, p} + {1'b0, edge_v} - {1'b0, step});
            // a position left above a shrunk edge still folds down by one edge
            else if ((p - step) > edge_v) wrap_step = p - step - edge_v;
            else          wrap_step = p - step;
         end else if (sum > {1'b0, edge_v}) begin
            wrap_step = EW'(sum - {1'b0, edge_v});
         end else begin
            wrap_step = sum[EW-1:0];
         end
      end
   endfunction

   assign in_range = ({3'd0, req_walker_id} < 7'(WALKERS));
   assign req_idx  = IW'(req_walker_id);

   assign s1_adv    = s1_vld_ff && ((s1_op_ff == rwop_pkg::OP_PLACE) || job_ready);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = s1_adv && s1_in_range_ff;

   always_comb begin
      if (fwd_vld_ff && (fwd_idx_ff == s1_idx_ff)) entry = fwd_data_ff;
      else if (rvld_ff)                            entry = rdata_ff;
      else                                         entry = '0;
   end

   assign old_x    = EW'(entry[POS_BITS-1:0]);
   assign old_y    = EW'(entry[2*POS_BITS-1:POS_BITS]);
   assign old_flag = entry[MW-1];

   always_comb begin
      edge_eff = EW'(cfg.grid_edge);
      if (edge_eff == '0) edge_eff = EW'(1);
      if (edge_eff > PMAX) edge_eff = PMAX;
      step_eff = (EW'(cfg.step_size) > edge_eff) ? edge_eff : EW'(cfg.step_size);
   end

   always_comb begin
      if (s1_op_ff == rwop_pkg::OP_PLACE) begin
         new_x = (EW'(s1_px_ff) > edge_eff) ? edge_eff : EW'(s1_px_ff);
         new_y = (EW'(s1_py_ff) > edge_eff) ? edge_eff : EW'(s1_py_ff);
      end else begin
         new_x = wrap_step(old_x, step_eff, s1_xneg_ff, edge_eff);
         new_y = wrap_step(old_y, step_eff, s1_yneg_ff, edge_eff);
      end
      new_flag = (new_x >= EW'(cfg.box_x_low)) && (new_x < EW'(cfg.box_x_high)) &&
                 (new_y >= EW'(cfg.box_y_low)) && (new_y < EW'(cfg.box_y_high));
      wr_data  = {new_flag, new_y[POS_BITS-1:0], new_x[POS_BITS-1:0]};
   end

   always_comb begin
      count_in = count_ff;
      if (s1_in_range_ff) begin
         if (new_flag && !old_flag)      count_in = count_ff + CW'(1);
         else if (!new_flag && old_flag) count_in = count_ff - CW'(1);
      end
   end

   // burst descriptor from the count after this item
   assign job_valid = s1_vld_ff && (s1_op_ff == rwop_pkg::OP_MOVE);
   always_comb begin
      job.pulse            = (count_in != '0);
      job.occupancy        = (32'(count_in) > 32'(rwop_pkg::OCC_MAX)) ?
                             rwop_pkg::OCC_MAX : 5'(count_in);
      job.multiple_present = (32'(count_in) > 32'd1);
      if (count_in == '0)
         job.beats = 5'd1;
      else if (32'(count_in) > 32'(rwop_pkg::MAX_BURST))
         job.beats = rwop_pkg::MAX_BURST;
      else
         job.beats = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         vld_ff     <= '0;
         count_ff   <= '0;
      end else begin
         if (accept) begin
            s1_vld_ff  <= 1'b1;
            fwd_vld_ff <= wr_en;
         end else if (s1_adv) begin
            s1_vld_ff  <= 1'b0;
         end
         if (wr_en) vld_ff[s1_idx_ff] <= 1'b1;
         if (s1_adv) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_operation;
         s1_in_range_ff <= in_range;
         s1_idx_ff      <= req_idx;
         s1_xneg_ff     <= req_x_negative;
         s1_yneg_ff     <= req_y_negative;
         s1_px_ff       <= req_place_x;
         s1_py_ff       <= req_place_y;
         rdata_ff       <= mem_ff[req_idx];
         rvld_ff        <= in_range && vld_ff[req_idx];
         fwd_idx_ff     <= s1_idx_ff;
         fwd_data_ff    <= wr_data;
      end
      if (wr_en) mem_ff[s1_idx_ff] <= wr_data;
   end

endmodule

[sv/rwop_burst.sv]
// Pulse burst generator with registered result stage.
// Depends on rwop_pkg.
module rwop_burst (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  rwop_pkg::job_type job,
   output logic              job_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_pulse,
   output logic [4:0]        rsp_occupancy,
   output logic              rsp_multiple_present,
   output logic              rsp_last
);

   logic              busy_ff;
   rwop_pkg::job_type cur_ff;
   logic [4:0]        left_ff;

   logic              rsp_vld_ff;
   logic              pulse_ff;
   logic [4:0]        occ_ff;
   logic              multi_ff;
   logic              last_ff;

   logic              emit;
   logic              final_beat;

   assign emit       = busy_ff && (!rsp_vld_ff || !rsp_stall);
   assign final_beat = (left_ff == 5'd1);
   assign job_ready  = !busy_ff || (emit && final_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (job_valid && job_ready) busy_ff <= 1'b1;
         else if (emit && final_beat) busy_ff <= 1'b0;
         if (emit)            rsp_vld_ff <= 1'b1;
         else if (!rsp_stall) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         cur_ff  <= job;
         left_ff <= job.beats;
      end else if (emit) begin
         left_ff <= left_ff - 5'd1;
      end
      if (emit) begin
         pulse_ff <= cur_ff.pulse;
         occ_ff   <= cur_ff.occupancy;
         multi_ff <= cur_ff.multiple_present;
         last_ff  <= final_beat;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_pulse            = pulse_ff;
   assign rsp_occupancy        = occ_ff;
   assign rsp_multiple_present = multi_ff;
   assign rsp_last             = last_ff;

endmodule

[sv/random_walk_occupancy_pulser.sv]
// Random walk occupancy pulser: each walker's x, y and in-box flag live in one
// synchronous memory of WALKERS entries. An accepted beat reads its walker on the
// accept edge and is updated and written back when it leaves the update stage,
// where a move may wait for the pulse generator; a write that lands on the same
// edge as the next read is bypassed, so back-to-back beats to one walker are
// exact. A place beat never waits and makes no result. A move beat hands a burst
// to the pulse generator, which puts out one result per cycle while rsp_stall is
// low: max(1, min(occupancy, 16)) results, the last flagged. The pulse generator
// is what sets the rate: a new beat is taken every cycle while it has room, so a
// stream of moves runs at one beat per burst length. A move's first result
// passes the update stage, burst and result registers. Walker state resets to
// zero through per-entry valid bits, so there is no clearing pass. Writing a box
// register does not re-test walkers; only a moved or placed walker is re-tested.
// Registers sit at byte address 4*index; write them only while the block is idle.
// Depends on rwop_pkg, rwop_csr, rwop_walker_store, rwop_burst.
module random_walk_occupancy_pulser #(
   parameter int WALKERS  = 16,
   parameter int POS_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [3:0]                     req_walker_id,
   input  logic                           req_x_negative,
   input  logic                           req_y_negative,
   input  logic [7:0]                     req_place_x,
   input  logic [7:0]                     req_place_y,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pulse,
   output logic [4:0]                     rsp_occupancy,
   output logic                           rsp_multiple_present,
   output logic                           rsp_last,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rwop_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   rwop_pkg::cfg_type cfg;
   rwop_pkg::job_type job;
   logic              job_valid;
   logic              job_ready;

   rwop_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // memory read-modify-write stage and occupancy count
   rwop_walker_store #(
      .WALKERS  (WALKERS),
      .POS_BITS (POS_BITS)
   ) u_store (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_walker_id  (req_walker_id),
      .req_x_negative (req_x_negative),
      .req_y_negative (req_y_negative),
      .req_place_x    (req_place_x),
      .req_place_y    (req_place_y),
      .job_valid      (job_valid),
      .job            (job),
      .job_ready      (job_ready)
   );

   // burst expansion into result beats
   rwop_burst u_burst (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (job_valid),
      .job                  (job),
      .job_ready            (job_ready),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pulse            (rsp_pulse),
      .rsp_occupancy        (rsp_occupancy),
      .rsp_multiple_present (rsp_multiple_present),
      .rsp_last             (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a burst never has gaps: after a non-final beat another one follows
   a_burst_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a pulse burst");

   // occupancy stays fixed within one burst
   a_burst_occ_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_occupancy == $past(rsp_occupancy))
      else $error("occupancy changed inside a burst");

   // an empty result is alone and reports an empty box
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pulse |-> rsp_last && rsp_occupancy == 5'd0 &&
                                  !rsp_multiple_present)
      else $error("malformed empty result");

   // multiple_present agrees with the occupancy carried alongside it
   a_multi_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_multiple_present == (rsp_occupancy > 5'd1))
      else $error("multiple_present disagrees with occupancy");
`endif

endmodule
